// File: hw/rtl/i2cdiv_pkg.sv
// Shared constants and types for the I2C clock divider pair search block.
package i2cdiv_pkg;

  localparam int unsigned ChanW     = 8;
  localparam int unsigned FreqW     = 12;
  localparam int unsigned SrcW      = 20;
  localparam int unsigned StatW     = 2;
  localparam int unsigned P1W       = 8;
  localparam int unsigned AchW      = 17;
  localparam int unsigned QuoKeepW  = 15;
  localparam int unsigned DvdW      = 24;
  localparam int unsigned DvsW      = 12;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 40;

  localparam int unsigned DefMaxSecondDivider = 128;

  localparam logic [SrcW-1:0]     SrcReset  = SrcW'(50000);
  localparam logic [FreqW-1:0]    FreqMin   = FreqW'(10);
  localparam logic [FreqW-1:0]    FreqMax   = FreqW'(3300);
  localparam logic [DvdW-1:0]     QuotLimit = DvdW'(25500);
  localparam logic [DvdW-1:0]     P1MinQuot = DvdW'(1500);
  localparam logic [DvsW-1:0]     Scale     = DvsW'(100);
  localparam logic [P1W-1:0]      P1Min     = P1W'(15);
  localparam logic [7:0]          P2Flag    = 8'h80;

  localparam logic [StatW-1:0] StatOk     = 2'd0;
  localparam logic [StatW-1:0] StatRange  = 2'd1;
  localparam logic [StatW-1:0] StatNoPair = 2'd2;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StDivTgt = 7'b0000010,
    StSearch = 7'b0000100,
    StDivP1  = 7'b0001000,
    StDivSrc = 7'b0010000,
    StDivP2  = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

endpackage

// File: hw/rtl/i2c_clock_divider_pair_search_top.sv
// Top level of the I2C clock divider pair search with one shared iterative divider.
//
//  Channel  | Direction | Handshake                       | Beat contents
//  s_axis   | in        | s_axis_tvalid / s_axis_tready   | channel, target_freq_khz
//  m_axis   | out       | m_axis_tvalid / m_axis_tready   | status .. achieved_freq_khz
//  cfg      | in        | cfg_valid_i / cfg_ready_o       | source_clock_khz
//
// Every division runs on one restoring divider at one quotient bit per cycle.
// A rejected beat skips the divider; otherwise up to 128 second dividers are tried.
// Reset sets the source clock to 50000 kHz and leaves the block idle and empty.
// A new beat is taken only while idle; a finished result waits in the output register.
module i2c_clock_divider_pair_search_top #(
  parameter int unsigned MAX_SECOND_DIVIDER = i2cdiv_pkg::DefMaxSecondDivider
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] channel, [19:8] target_freq_khz, [23:20] zero
  input  logic [i2cdiv_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [2] channel_echo, [10:3] first_divider, [18:11] second_divider_byte,
  // [35:19] achieved_freq_khz, [39:36] zero
  output logic [i2cdiv_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [i2cdiv_pkg::SrcW-1:0]     cfg_data_i
);

  import i2cdiv_pkg::*;

  localparam int unsigned P2W  = $clog2(MAX_SECOND_DIVIDER + 1);
  localparam int unsigned CntW = $clog2(DvdW + 1);
  localparam logic [CntW-1:0] DivSteps = CntW'(DvdW);
  localparam logic [P2W-1:0]  P2Last   = P2W'(MAX_SECOND_DIVIDER);

  state_e st_q, st_d;

  logic [SrcW-1:0]     src_q, src_d;
  logic                chan_q, chan_d;
  logic [StatW-1:0]    stat_q, stat_d;
  logic [DvdW-1:0]     target_q, target_d;
  logic [P2W-1:0]      p2_q, p2_d;
  logic                found_q, found_d;
  logic [DvsW-1:0]     best_rem_q, best_rem_d;
  logic [QuoKeepW-1:0] best_quo_q, best_quo_d;
  logic [P2W-1:0]      best_p2_q, best_p2_d;
  logic [P1W-1:0]      p1_q, p1_d;

  logic [DvdW-1:0] quo_q, quo_d;
  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic            div_busy;
  logic [DvsW:0]   shl;
  logic [DvsW:0]   diff;
  logic            ge;
  logic            launch;
  logic [DvdW-1:0] l_dvd;
  logic [DvsW-1:0] l_dvs;

  logic [ChanW-1:0] in_chan;
  logic [FreqW-1:0] in_freq;
  logic [DvdW-1:0]  tgt_new;
  logic             improve;
  logic             in_limit;
  logic             accept;
  logic [8:0]       p2m1;
  logic [7:0]       p2_byte;
  logic             is_ok;
  logic [P2W-1:0]   p2_next;

  assign in_chan = s_axis_tdata[ChanW-1:0];
  assign in_freq = s_axis_tdata[ChanW+FreqW-1:ChanW];

  assign div_busy = (cnt_q != DivSteps);
  assign shl      = {rem_q, quo_q[DvdW-1]};
  assign diff     = shl - {1'b0, dvs_q};
  assign ge       = (shl >= {1'b0, dvs_q});

  assign tgt_new  = {quo_q[DvdW-7:0], 6'b0} + {quo_q[DvdW-6:0], 5'b0} + {quo_q[DvdW-3:0], 2'b0};
  assign improve  = !found_q || (rem_q < best_rem_q);
  assign in_limit = (quo_q <= QuotLimit);
  assign accept   = improve && in_limit && (quo_q >= P1MinQuot);
  assign p2_next  = p2_q + 1'b1;

  assign p2m1    = 9'(best_p2_q) - 9'd1;
  assign p2_byte = p2m1[7:0] | P2Flag;
  assign is_ok   = (stat_q == StatOk);

  assign s_axis_tready = (st_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    st_d       = st_q;
    src_d      = src_q;
    chan_d     = chan_q;
    stat_d     = stat_q;
    target_d   = target_q;
    p2_d       = p2_q;
    found_d    = found_q;
    best_rem_d = best_rem_q;
    best_quo_d = best_quo_q;
    best_p2_d  = best_p2_q;
    p1_d       = p1_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    launch     = 1'b0;
    l_dvd      = quo_q;
    l_dvs      = dvs_q;

    if (cfg_valid_i) begin
      src_d = cfg_data_i;
    end
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          if (in_freq > FreqMax || in_freq < FreqMin || in_chan > ChanW'(1)) begin
            stat_d = StatRange;
            chan_d = 1'b0;
            st_d   = StDone;
          end else begin
            chan_d  = in_chan[0];
            found_d = 1'b0;
            launch  = 1'b1;
            l_dvd   = DvdW'(src_q);
            l_dvs   = in_freq;
            st_d    = StDivTgt;
          end
        end
      end
      StDivTgt: begin
        if (!div_busy) begin
          target_d = tgt_new;
          p2_d     = P2W'(1);
          launch   = 1'b1;
          l_dvd    = tgt_new;
          l_dvs    = DvsW'(1);
          st_d     = StSearch;
        end
      end
      StSearch: begin
        if (!div_busy) begin
          if (accept) begin
            found_d    = 1'b1;
            best_rem_d = rem_q;
            best_quo_d = quo_q[QuoKeepW-1:0];
            best_p2_d  = p2_q;
          end
          if ((improve && in_limit && !accept) || p2_q == P2Last) begin
            if (found_d) begin
              launch = 1'b1;
              l_dvd  = DvdW'(best_quo_d);
              l_dvs  = Scale;
              st_d   = StDivP1;
            end else begin
              stat_d = StatNoPair;
              st_d   = StDone;
            end
          end else begin
            p2_d   = p2_next;
            launch = 1'b1;
            l_dvd  = target_q;
            l_dvs  = DvsW'(p2_next);
          end
        end
      end
      StDivP1: begin
        if (!div_busy) begin
          p1_d   = quo_q[P1W-1:0];
          launch = 1'b1;
          l_dvd  = DvdW'(src_q);
          l_dvs  = DvsW'(quo_q[P1W-1:0]);
          st_d   = StDivSrc;
        end
      end
      StDivSrc: begin
        if (!div_busy) begin
          launch = 1'b1;
          l_dvd  = quo_q;
          l_dvs  = DvsW'(best_p2_q);
          st_d   = StDivP2;
        end
      end
      StDivP2: begin
        if (!div_busy) begin
          stat_d = StatOk;
          st_d   = StDone;
        end
      end
      StDone: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {4'b0,
                       is_ok ? quo_q[AchW-1:0] : AchW'(0),
                       is_ok ? p2_byte : 8'd0,
                       is_ok ? p1_q : P1W'(0),
                       chan_q,
                       stat_q};
          st_d      = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase

    if (launch) begin
      quo_d = l_dvd;
      rem_d = '0;
      dvs_d = l_dvs;
      cnt_d = '0;
    end else if (div_busy) begin
      quo_d = {quo_q[DvdW-2:0], ge};
      rem_d = ge ? diff[DvsW-1:0] : shl[DvsW-1:0];
      dvs_d = dvs_q;
      cnt_d = cnt_q + 1'b1;
    end else begin
      quo_d = quo_q;
      rem_d = rem_q;
      dvs_d = dvs_q;
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      src_q     <= SrcReset;
      found_q   <= 1'b0;
      cnt_q     <= DivSteps;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      src_q     <= src_d;
      found_q   <= found_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q     <= chan_d;
    stat_q     <= stat_d;
    target_q   <= target_d;
    p2_q       <= p2_d;
    best_rem_q <= best_rem_d;
    best_quo_q <= best_quo_d;
    best_p2_q  <= best_p2_d;
    p1_q       <= p1_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    m_data_q   <= m_data_d;
  end

  a_best_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (DvdW'(best_quo_q) >= P1MinQuot) && (DvdW'(best_quo_q) <= QuotLimit))
    else $error("kept quotient outside the accepted window");

  a_p2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSearch) |-> (p2_q != '0) && (p2_q <= P2Last))
    else $error("second divider candidate out of range");

  a_rem_below_dvs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle && st_q != StDone && st_q != StDivTgt) |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

  a_ok_p1_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[StatW-1:0] == StatOk) |-> (m_data_q[StatW+P1W:StatW+1] >= P1Min))
    else $error("first divider below minimum on a good result");

endmodule

// File: tb/i2cdiv_pair_checker.sv
// Checker that predicts each divider pair result and compares it with the block's output.
`timescale 1ns / 100ps

module i2cdiv_pair_checker #(
  parameter int unsigned MaxSecondDivider = i2cdiv_pkg::DefMaxSecondDivider
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  input  logic [i2cdiv_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  input  logic [i2cdiv_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [i2cdiv_pkg::SrcW-1:0]     cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  import i2cdiv_pkg::*;

  typedef struct packed {
    logic [AchW-1:0]  ach_khz;
    logic [7:0]       p2_byte;
    logic [P1W-1:0]   p1;
    logic             chan_echo;
    logic [StatW-1:0] status;
  } div_result_t;

  localparam int unsigned ResW = $bits(div_result_t);

  logic [SrcW-1:0] src_khz;
  div_result_t     expected_divs[$];
  div_result_t     got_div;
  div_result_t     want_div;
  int              mismatches = 0;
  int              results_seen = 0;

  assign fail_count_o = mismatches;

  function automatic div_result_t search_divider_pair(input logic [SrcW-1:0] src,
                                                       input logic [ChanW-1:0] chan,
                                                       input logic [FreqW-1:0] freq);
    div_result_t r;
    int unsigned src_u;
    int unsigned target;
    int unsigned rem;
    int unsigned quo;
    int unsigned p1;
    int unsigned best_rem;
    int unsigned best_p1;
    int unsigned best_p2;
    bit          found;
    r        = '0;
    src_u    = src;
    best_rem = 0;
    best_p1  = 0;
    best_p2  = 1;
    found    = 1'b0;
    if (freq > FreqMax || freq < FreqMin || chan > 1) begin
      r.status = StatRange;
      return r;
    end
    target = (src_u / 32'(freq)) * 32'(Scale);
    for (int unsigned p2 = 1; p2 <= MaxSecondDivider; p2++) begin
      rem = target % p2;
      if (!found || rem < best_rem) begin
        quo = target / p2;
        if (quo > 32'(QuotLimit)) continue;
        p1 = quo / 32'(Scale);
        if (p1 < 32'(P1Min)) break;
        best_rem = rem;
        best_p1  = p1;
        best_p2  = p2;
        found    = 1'b1;
      end
    end
    r.chan_echo = chan[0];
    if (!found) begin
      r.status = StatNoPair;
      return r;
    end
    r.status  = StatOk;
    r.p1      = best_p1[P1W-1:0];
    r.p2_byte = 8'(best_p2 - 1) | P2Flag;
    r.ach_khz = AchW'(src_u / best_p1 / best_p2);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
             $realtime, results_seen, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_khz <= SrcReset;
      expected_divs.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_div = div_result_t'(m_tdata_i[ResW-1:0]);
        results_seen++;
        if (expected_divs.size() == 0) begin
          report_mismatch("beat with nothing outstanding", 64'(got_div), 64'd0);
        end else begin
          want_div = expected_divs.pop_front();
          if (got_div.status !== want_div.status)
            report_mismatch("status", 64'(got_div.status), 64'(want_div.status));
          if (got_div.chan_echo !== want_div.chan_echo)
            report_mismatch("channel_echo", 64'(got_div.chan_echo), 64'(want_div.chan_echo));
          if (got_div.p1 !== want_div.p1)
            report_mismatch("first_divider", 64'(got_div.p1), 64'(want_div.p1));
          if (got_div.p2_byte !== want_div.p2_byte)
            report_mismatch("second_divider_byte", 64'(got_div.p2_byte),
                            64'(want_div.p2_byte));
          if (got_div.ach_khz !== want_div.ach_khz)
            report_mismatch("achieved_freq_khz", 64'(got_div.ach_khz),
                            64'(want_div.ach_khz));
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_divs.push_back(search_divider_pair(src_khz, s_tdata_i[7:0], s_tdata_i[19:8]));
      if (cfg_valid_i && cfg_ready_i) src_khz <= cfg_data_i;
      pending_o <= expected_divs.size();
    end
  end

endmodule

// File: tb/i2c_clock_divider_pair_search_top_test.sv
// Testbench top that drives requests and clock settings into the divider pair search.
`timescale 1ns / 100ps

module i2c_clock_divider_pair_search_top_test;
  import i2cdiv_pkg::*;

  localparam int unsigned MaxP2         = DefMaxSecondDivider;
  localparam int          HoldCycles    = 6000;
  localparam int          WatchdogLimit = 50000;
  localparam int          TailCycles    = 3500;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [SrcW-1:0]     cfg_data_i = '0;

  int fail_count;
  int pending;
  int n_beats = 0;
  int n_settings = 0;
  int quiet = 0;
  int hold_serial = 0;
  int hold_seen = 0;
  int hold_left = 0;
  bit calm = 1'b0;

  i2c_clock_divider_pair_search_top #(
    .MAX_SECOND_DIVIDER(MaxP2)
  ) DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i
  );

  i2cdiv_pair_checker #(
    .MaxSecondDivider(MaxP2)
  ) checker_i (
    .clk_i,
    .rst_ni,
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i,
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i,
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_serial) begin
      hold_seen <= hold_serial;
      hold_left <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (calm || !rst_ni) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_beat(input logic [ChanW-1:0] chan, input logic [FreqW-1:0] freq);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, freq, chan};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_beats++;
  endtask

  task automatic send_random_beat();
    if ($urandom_range(99) < 80)
      send_beat(ChanW'($urandom_range(1)), FreqW'($urandom_range(10, 3300)));
    else
      send_beat(ChanW'($urandom_range(255)), FreqW'($urandom_range(4095)));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_source_clock(input logic [SrcW-1:0] khz);
    drain();
    repeat (4) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= khz;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_beat(8'd0, 12'd0);
    send_beat(8'd0, 12'd9);
    send_beat(8'd0, 12'd10);
    send_beat(8'd1, 12'd3300);
    send_beat(8'd0, 12'd3301);
    send_beat(8'd1, 12'd4095);
    send_beat(8'd2, 12'd100);
    send_beat(8'd255, 12'd100);
    send_beat(8'd1, 12'd100);
    send_beat(8'd0, 12'd400);
    send_beat(8'd1, 12'd1000);
    send_beat(8'd0, 12'd2048);
    send_beat(8'd1, 12'd1);

    write_source_clock(SrcW'(1));
    send_beat(8'd0, 12'd10);
    send_beat(8'd1, 12'd3300);

    write_source_clock(SrcW'(0));
    send_beat(8'd1, 12'd100);

    write_source_clock(SrcW'(1000000));
    send_beat(8'd0, 12'd10);
    send_beat(8'd1, 12'd3300);
    send_beat(8'd0, 12'd400);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_source_clock(SrcReset);
        1: write_source_clock(SrcW'($urandom_range(1000, 200000)));
        2: write_source_clock(SrcW'($urandom_range(1, 1000000)));
        default: write_source_clock(SrcW'($urandom_range(8000, 120000)));
      endcase
      calm = (ph == 1);
      for (int k = 0; k < 30; k++) begin
        if (ph == 2 && k == 8) hold_serial++;
        if (ph == 3 && k == 17) drain();
        send_random_beat();
      end
    end

    drain();
    repeat (TailCycles) @(negedge clk_i);
    $display("Covered %0d request beats under %0d source clock settings,", n_beats, n_settings);
    $display("with random gaps on both sides, one long output stall and one input pause.");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
